// ----- rtl/sitc_pkg.sv -----
// ----------------------------------------------------------------------------
// sitc_pkg: shared types and constants
// Constants, register codes and queue-entry flags used across the signed
// integer to radix digits converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sitc_pkg;

  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned LEN_W        = 5;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned SYMS_PER_REG = 8;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LENGTH       = 2'd0,
    CFG_LOW_SYMBOLS  = 2'd1,
    CFG_HIGH_SYMBOLS = 2'd2
  } cfg_reg_e;

  // Classification that travels with each queued item.
  typedef struct packed {
    logic bad;
    logic neg;
  } item_flags_t;

endpackage

`default_nettype wire

// ----- rtl/sitc_front.sv -----
// ----------------------------------------------------------------------------
// sitc_front: input acceptance and classification
// Accepts values, validates the alphabet and forms sign and magnitude for
// the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sitc_front
  import sitc_pkg::*;
#(
  parameter int unsigned MAX_ALPHABET = 16,
  parameter int unsigned VALUE_WIDTH  = 32,
  parameter int unsigned IN_W         = 32
) (
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [IN_W-1:0]                       s_axis_tdata,
  input  wire logic [LEN_W-1:0]                      len_i,
  input  wire logic [MAX_ALPHABET-1:0][CHAR_W-1:0]   sym_i,
  input  wire logic                                  fifo_full_i,
  output logic                                       push_o,
  output item_flags_t                                flags_o,
  output logic [VALUE_WIDTH-1:0]                     mag_o
);

  logic [VALUE_WIDTH-1:0] value;
  logic                   bad;

  assign value = s_axis_tdata[VALUE_WIDTH-1:0];

  // Needs length 2..MAX_ALPHABET, no '+' or '-', and distinct symbols below it.
  always_comb begin
    bad = (len_i < LEN_W'(2)) || (len_i > LEN_W'(MAX_ALPHABET));
    for (int i = 0; i < MAX_ALPHABET; i++) begin
      if (LEN_W'(i) < len_i) begin
        if (sym_i[i] == CHAR_PLUS || sym_i[i] == CHAR_MINUS) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < MAX_ALPHABET; j++) begin
          if (LEN_W'(j) < len_i && sym_i[i] == sym_i[j]) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  assign s_axis_tready = !fifo_full_i;
  assign push_o        = s_axis_tvalid && !fifo_full_i;
  assign flags_o.bad   = bad;
  assign flags_o.neg   = value[VALUE_WIDTH-1];
  // The most negative value wraps to 2**(VALUE_WIDTH-1), which is exact unsigned.
  assign mag_o = value[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - value) : value;

endmodule

`default_nettype wire

// ----- rtl/sitc_fifo.sv -----
// ----------------------------------------------------------------------------
// sitc_fifo: two-entry queue
// Decouples the classifying front end from the converting back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sitc_fifo #(
  parameter int unsigned WIDTH = 34
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][WIDTH-1:0] mem_q;
  logic                        wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]            cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
      mem_q    <= '0;
    end else begin
      if (push_i) begin
        mem_q[wr_ptr_q] <= wdata_i;
        wr_ptr_q        <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sitc_back.sv -----
// ----------------------------------------------------------------------------
// sitc_back: digit generation and character output
// Divides the magnitude by the radix eight quotient bits per cycle, keeps
// the remainders in a digit memory and replays them most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module sitc_back
  import sitc_pkg::*;
#(
  parameter int unsigned MAX_ALPHABET = 16,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [LEN_W-1:0]                    len_i,
  input  wire logic [MAX_ALPHABET-1:0][CHAR_W-1:0] sym_i,
  input  wire logic                                fifo_empty_i,
  input  wire item_flags_t                         head_flags_i,
  input  wire logic [VALUE_WIDTH-1:0]              head_mag_i,
  output logic                                     pop_o,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [CHAR_W-1:0]                        m_axis_tdata,
  output logic                                     m_axis_tlast,
  output logic                                     m_axis_tuser
);

  localparam int unsigned DIGIT_W   = $clog2(MAX_ALPHABET);
  localparam int unsigned NCH       = (VALUE_WIDTH + 7) / 8;
  localparam int unsigned WP        = NCH * 8;
  localparam int unsigned CNT_W     = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned IDX_W     = $clog2(VALUE_WIDTH);
  localparam int unsigned CH_W      = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned BITS_STEP = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_SEND
  } state_e;

  state_e             state_q;
  logic [WP-1:0]      work_q;
  logic [DIGIT_W-1:0] rem_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CH_W-1:0]    chunk_q;
  logic               neg_q;
  logic [IDX_W-1:0]   idx_q;
  logic               out_valid_q, out_last_q, out_bad_q;
  logic [CHAR_W-1:0]  out_char_q;

  logic [DIGIT_W-1:0] digit_mem [VALUE_WIDTH];
  logic [DIGIT_W-1:0] rd_digit_q;

  logic [DIGIT_W:0]   radix;
  logic [WP-1:0]      step_w;
  logic [DIGIT_W-1:0] step_r;
  logic [DIGIT_W:0]   trial;
  logic               slot_free;
  logic               out_load;
  logic               digit_done;
  logic [CNT_W-1:0]   cnt_plus;

  assign radix      = len_i[DIGIT_W:0];
  assign slot_free  = !out_valid_q || m_axis_tready;
  assign digit_done = (state_q == ST_DIV) && (chunk_q == CH_W'(NCH - 1));
  assign cnt_plus   = cnt_q + 1'b1;
  assign pop_o      = (state_q == ST_IDLE) && !fifo_empty_i &&
                      (slot_free || !head_flags_i.bad);
  // A new character enters the output register in this cycle.
  assign out_load   = slot_free &&
                      (((state_q == ST_IDLE) && pop_o && head_flags_i.bad) ||
                       (state_q == ST_SIGN) || (state_q == ST_SEND));

  // Restoring long division, eight quotient bits per cycle. The remainder
  // stays below the radix, so each step is a narrow compare and subtract.
  always_comb begin
    step_w = work_q;
    step_r = rem_q;
    trial  = '0;
    for (int b = 0; b < BITS_STEP; b++) begin
      trial  = {step_r, step_w[WP-1]};
      step_w = {step_w[WP-2:0], 1'b0};
      if (trial >= radix) begin
        trial     = trial - radix;
        step_w[0] = 1'b1;
      end
      step_r = trial[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (digit_done) begin
      digit_mem[cnt_q[IDX_W-1:0]] <= step_r;
    end
    rd_digit_q <= digit_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      work_q      <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      chunk_q     <= '0;
      neg_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
      out_bad_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            if (head_flags_i.bad) begin
              out_char_q  <= '0;
              out_last_q  <= 1'b1;
              out_bad_q   <= 1'b1;
            end else begin
              work_q  <= WP'(head_mag_i);
              rem_q   <= '0;
              cnt_q   <= '0;
              chunk_q <= '0;
              neg_q   <= head_flags_i.neg;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          work_q <= step_w;
          if (digit_done) begin
            rem_q   <= '0;
            chunk_q <= '0;
            cnt_q   <= cnt_plus;
            if (step_w == '0 || cnt_plus == CNT_W'(VALUE_WIDTH)) begin
              idx_q   <= cnt_q[IDX_W-1:0];
              state_q <= neg_q ? ST_SIGN : ST_READ;
            end
          end else begin
            rem_q   <= step_r;
            chunk_q <= chunk_q + 1'b1;
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            out_char_q  <= CHAR_MINUS;
            out_last_q  <= 1'b0;
            out_bad_q   <= 1'b0;
            state_q     <= ST_READ;
          end
        end
        ST_READ: begin
          // The digit memory read is registered; this state waits for its data.
          state_q <= ST_SEND;
        end
        ST_SEND: begin
          if (slot_free) begin
            out_char_q  <= sym_i[rd_digit_q];
            out_last_q  <= (idx_q == '0);
            out_bad_q   <= 1'b0;
            if (idx_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q - 1'b1;
              state_q <= ST_READ;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_bad_q;

  a_digit_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(VALUE_WIDTH))
    else $error("digit count exceeds value width");

  a_error_item_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_bad_q) |-> (out_last_q && out_char_q == '0))
    else $error("error result must be a single zero character");

  a_remainder_below_radix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < radix))
    else $error("partial remainder not below radix");

endmodule

`default_nettype wire

// ----- rtl/signed_integer_to_radix_digits_core.sv -----
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_core: signed integer to text converter
// Streams the text of a signed value in a configured base alphabet.
// ----------------------------------------------------------------------------
// Usage: write the alphabet length (index 0) and its symbols (indexes 1 and
// 2, lowest byte first) through the cfg channel while the block is idle.
// Each s_axis transaction carries one value; the block answers with one
// m_axis transaction per character: a '-' for negatives, then the digits
// most significant first, tlast on the final one. If the alphabet is bad
// (length below two or above MAX_ALPHABET, a '+' or '-' symbol, or a repeated
// symbol) the answer is one transaction with tdata zero and tuser and tlast
// high. The value is taken from the queue, then the divider, which yields
// eight quotient bits a cycle, passes over the whole byte-padded magnitude
// for each digit; the sign follows for a negative value, and each digit
// character is read from the digit memory before it is sent. A two-entry
// queue lets up to two further values be accepted while one converts. Reset
// empties the queue, returns the back end to idle and clears the alphabet.
// When the receiver stalls, the output register holds its character and the
// back end waits before loading the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_to_radix_digits_core
  import sitc_pkg::*;
#(
  parameter int unsigned MAX_ALPHABET = 16,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // [VALUE_WIDTH-1:0] value, zero padding up to a whole byte.
  input  wire logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // [7:0] character.
  output logic [CHAR_W-1:0]            m_axis_tdata,
  output logic                         m_axis_tlast,
  // [0] bad_alphabet.
  output logic                         m_axis_tuser,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned IN_W    = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int unsigned ENTRY_W = VALUE_WIDTH + $bits(item_flags_t);

  logic [LEN_W-1:0]                    len_q;
  logic [MAX_ALPHABET-1:0][CHAR_W-1:0] sym_q;

  logic                   push, pop, fifo_full, fifo_empty;
  item_flags_t            push_flags, head_flags;
  logic [VALUE_WIDTH-1:0] push_mag, head_mag;
  logic [ENTRY_W-1:0]     head_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      sym_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_LENGTH: len_q <= cfg_data_i[LEN_W-1:0];
        CFG_LOW_SYMBOLS: begin
          for (int k = 0; k < MAX_ALPHABET; k++) begin
            if (k < SYMS_PER_REG) begin
              sym_q[k] <= cfg_data_i[CHAR_W*(k % SYMS_PER_REG) +: CHAR_W];
            end
          end
        end
        CFG_HIGH_SYMBOLS: begin
          for (int k = 0; k < MAX_ALPHABET; k++) begin
            if (k >= SYMS_PER_REG) begin
              sym_q[k] <= cfg_data_i[CHAR_W*(k % SYMS_PER_REG) +: CHAR_W];
            end
          end
        end
        default: ;
      endcase
    end
  end

  sitc_front #(
    .MAX_ALPHABET (MAX_ALPHABET),
    .VALUE_WIDTH  (VALUE_WIDTH),
    .IN_W         (IN_W)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .len_i         (len_q),
    .sym_i         (sym_q),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .flags_o       (push_flags),
    .mag_o         (push_mag)
  );

  sitc_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({push_flags, push_mag}),
    .pop_i   (pop),
    .rdata_o (head_entry),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  assign head_flags = head_entry[ENTRY_W-1:VALUE_WIDTH];
  assign head_mag   = head_entry[VALUE_WIDTH-1:0];

  sitc_back #(
    .MAX_ALPHABET (MAX_ALPHABET),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .len_i         (len_q),
    .sym_i         (sym_q),
    .fifo_empty_i  (fifo_empty),
    .head_flags_i  (head_flags),
    .head_mag_i    (head_mag),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire
